// File: hw/rtl/hbr_pkg.sv
// Shared types and constants for the HDLC bit receiver.
// No dependencies; used by every module of the block.
package hbr_pkg;

    // Upper bound on stored bytes per frame, on top of max_frame_bytes.
    localparam int unsigned MAX_FRAME = 4096;

    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned LEN_W      = 13;

    localparam logic [7:0] FLAG_PATTERN = 8'h7E;
    localparam logic [2:0] ONES_STUFF   = 3'd5;
    localparam logic [2:0] ONES_ABORT   = 3'd7;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NRZI_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = 2'd2;

    // Reset values of the configuration registers
    localparam logic             RST_NRZI_ENABLE = 1'b1;
    localparam logic [7:0]       RST_MIN_FRAME   = 8'd4;
    localparam logic [LEN_W-1:0] RST_MAX_FRAME   = 13'd4096;

    typedef enum logic [1:0] {
        EV_BYTE = 2'd0,
        EV_DONE = 2'd1,
        EV_DROP = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        CAUSE_SHORT    = 2'd0,
        CAUSE_ABORT    = 2'd1,
        CAUSE_OVERFLOW = 2'd2
    } drop_cause_t;

    typedef struct packed {
        logic             nrzi_enable;
        logic [7:0]       min_frame_bytes;
        logic [LEN_W-1:0] max_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        event_kind_t      kind;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] frame_length;
        drop_cause_t      drop_cause;
    } result_t;

endpackage

// File: hw/rtl/hdlc_bit_receiver.sv
// Top level of the HDLC bit receiver: input beat register, frame engine, result register.
// Depends on hbr_pkg, hbr_cfg_regs and hbr_frame_engine.

// HDLC bit receiver. Each input beat carries one line bit in s_tdata[0]. The
// bit is optionally NRZI-decoded (no level change = 1), searched for the 0x7E
// flag, destuffed (a zero after five ones is removed), checked for abort
// (seven ones in a row) and packed into bytes LSB first. Every stored byte
// gives a result beat, and the end of a frame gives a completion beat with the
// length or a drop beat with its cause. The block takes one bit per clock
// cycle sustained while m_tready is high: the whole step for a bit is
// combinational logic between the input register and the result register,
// so a bit goes in every cycle and its result is held in the result register
// until taken. A bit that produces no result still takes its turn. No clearing
// pass follows reset. Configuration writes on cfg_we/cfg_index/cfg_wdata take
// effect on the next cycle and belong in idle periods.
module hdlc_bit_receiver (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input bit stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] line_bit, [7:1] zero
    // result events
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // [7:0] data_byte,
                                                      // [20:8] frame_length,
                                                      // [22:21] drop_cause, [23] zero
    output logic [1:0]                     m_tuser,   // [1:0] event_kind
    // configuration writes
    input  logic                           cfg_we,
    input  logic [hbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    hbr_pkg::cfg_t    cfg;
    hbr_pkg::result_t result;

    logic             in_valid_reg;
    logic             in_bit_reg;
    logic             advance;

    logic             out_valid_reg;
    hbr_pkg::result_t out_reg;

    hbr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Advance the held bit whenever the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Hold the bit payload with its valid flag; no reset needed.
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_bit_reg <= s_tdata[0];
        end
    end

    hbr_frame_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .step     (advance),
        .line_bit (in_bit_reg),
        .result   (result)
    );

    // Result register: load on advance, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= result.valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {1'b0, out_reg.drop_cause, out_reg.frame_length, out_reg.data_byte};

endmodule

// File: hw/rtl/hbr_cfg_regs.sv
// Configuration register file of the HDLC bit receiver.
// Depends on hbr_pkg for register indexes, reset values and cfg_t.
module hbr_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [hbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output hbr_pkg::cfg_t                    cfg
);

    hbr_pkg::cfg_t cfg_reg;
    hbr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                hbr_pkg::REG_NRZI_ENABLE: cfg_next.nrzi_enable     = cfg_wdata[0];
                hbr_pkg::REG_MIN_FRAME:   cfg_next.min_frame_bytes = cfg_wdata[7:0];
                hbr_pkg::REG_MAX_FRAME:   cfg_next.max_frame_bytes = cfg_wdata;
                default:                  cfg_next = cfg_reg; // unmapped index: drop
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.nrzi_enable     <= hbr_pkg::RST_NRZI_ENABLE;
            cfg_reg.min_frame_bytes <= hbr_pkg::RST_MIN_FRAME;
            cfg_reg.max_frame_bytes <= hbr_pkg::RST_MAX_FRAME;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/hbr_frame_engine.sv
// Per-bit HDLC state: NRZI decode, flag search, destuffing, abort check, byte assembly.
// Depends on hbr_pkg; advances one bit on each cycle that step is high.
module hbr_frame_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  hbr_pkg::cfg_t     cfg,
    input  logic              step,
    input  logic              line_bit,
    output hbr_pkg::result_t  result
);

    localparam int unsigned LW = hbr_pkg::LEN_W;

    logic          prev_level_reg,   prev_level_next;
    logic [7:0]    shifter_reg,      shifter_next;
    logic          inside_reg,       inside_next;
    logic [2:0]    ones_reg,         ones_next;
    logic [2:0]    bit_pos_reg,      bit_pos_next;
    logic [7:0]    partial_reg,      partial_next;
    logic [LW-1:0] count_reg,        count_next;

    hbr_pkg::result_t res;

    always_comb begin
        logic       bit_val;
        logic [2:0] ones_inc;
        logic [7:0] byte_val;
        logic       room;

        bit_val  = cfg.nrzi_enable ? (line_bit == prev_level_reg) : line_bit;
        ones_inc = (ones_reg < hbr_pkg::ONES_ABORT) ? ones_reg + 3'd1 : ones_reg;
        byte_val = partial_reg;
        byte_val[bit_pos_reg] = bit_val;
        room = (count_reg < cfg.max_frame_bytes) &&
               (32'(count_reg) < hbr_pkg::MAX_FRAME);

        prev_level_next = line_bit;
        shifter_next    = {bit_val, shifter_reg[7:1]};
        inside_next     = inside_reg;
        ones_next       = ones_reg;
        bit_pos_next    = bit_pos_reg;
        partial_next    = partial_reg;
        count_next      = count_reg;

        res              = '0;
        res.kind         = hbr_pkg::EV_BYTE;
        res.drop_cause   = hbr_pkg::CAUSE_SHORT;

        if (shifter_next == hbr_pkg::FLAG_PATTERN) begin
            if (inside_reg && (count_reg >= LW'(cfg.min_frame_bytes))) begin
                // closing flag of a valid frame; wait for the next flag
                inside_next      = 1'b0;
                res.valid        = 1'b1;
                res.kind         = hbr_pkg::EV_DONE;
                res.frame_length = count_reg;
            end else begin
                if (inside_reg && (count_reg != '0)) begin
                    res.valid      = 1'b1;
                    res.kind       = hbr_pkg::EV_DROP;
                    res.drop_cause = hbr_pkg::CAUSE_SHORT;
                end
                inside_next  = 1'b1;
                ones_next    = '0;
                bit_pos_next = '0;
                partial_next = '0;
                count_next   = '0;
            end
        end else if (inside_reg) begin
            if (bit_val && (ones_inc == hbr_pkg::ONES_ABORT)) begin
                // abort: seventh one in a row
                inside_next  = 1'b0;
                ones_next    = '0;
                bit_pos_next = '0;
                partial_next = '0;
                count_next   = '0;
                if (count_reg != '0) begin
                    res.valid      = 1'b1;
                    res.kind       = hbr_pkg::EV_DROP;
                    res.drop_cause = hbr_pkg::CAUSE_ABORT;
                end
            end else if (!bit_val && (ones_reg == hbr_pkg::ONES_STUFF)) begin
                ones_next = '0; // drop the stuffed zero
            end else begin
                ones_next    = bit_val ? ones_inc : 3'd0;
                bit_pos_next = bit_pos_reg + 3'd1;
                partial_next = byte_val;
                if (bit_pos_reg == 3'd7) begin
                    partial_next = '0;
                    if (room) begin
                        count_next    = count_reg + LW'(1);
                        res.valid     = 1'b1;
                        res.kind      = hbr_pkg::EV_BYTE;
                        res.data_byte = byte_val;
                    end else begin
                        inside_next    = 1'b0;
                        ones_next      = '0;
                        bit_pos_next   = '0;
                        count_next     = '0;
                        res.valid      = 1'b1;
                        res.kind       = hbr_pkg::EV_DROP;
                        res.drop_cause = hbr_pkg::CAUSE_OVERFLOW;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= 1'b1;
            shifter_reg    <= '0;
            inside_reg     <= 1'b0;
            ones_reg       <= '0;
            bit_pos_reg    <= '0;
            partial_reg    <= '0;
            count_reg      <= '0;
        end else if (step) begin
            prev_level_reg <= prev_level_next;
            shifter_reg    <= shifter_next;
            inside_reg     <= inside_next;
            ones_reg       <= ones_next;
            bit_pos_reg    <= bit_pos_next;
            partial_reg    <= partial_next;
            count_reg      <= count_next;
        end
    end

    assign result = res;

endmodule

// File: hw/rtl/hbr_checker.sv
// Port-level checks for the HDLC bit receiver, bound to hdlc_bit_receiver.
// Depends on hbr_pkg for event and cause codes.
module hbr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Result register comes out of reset empty.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    // A stalled result beat holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // A byte beat carries only the byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == hbr_pkg::EV_BYTE) |-> m_tdata[23:8] == '0)
        else $error("byte beat carries length or cause");

    // A completion beat carries only the length, never above the frame cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == hbr_pkg::EV_DONE) |->
        (m_tdata[7:0] == '0) && (m_tdata[23:21] == '0) &&
        (32'(m_tdata[20:8]) <= hbr_pkg::MAX_FRAME))
        else $error("bad completion beat");

    // A drop beat carries a known cause and nothing else; no other kind exists.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == hbr_pkg::EV_BYTE) || (m_tuser == hbr_pkg::EV_DONE) ||
        ((m_tuser == hbr_pkg::EV_DROP) && (m_tdata[20:0] == '0) &&
         (m_tdata[22:21] != 2'd3) && !m_tdata[23]))
        else $error("bad drop beat or unknown event kind");

endmodule

bind hdlc_bit_receiver hbr_checker u_hbr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
